// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while reset is asserted.
`define KRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication: whenever cond holds, prop must hold in the same cycle.
`define KRF_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== hdl/krf_pkg.sv =====
// ---------------------------------------------------------------------------
// krf_pkg
// Shared types and constants of the k-mer repeat fraction block.
// ---------------------------------------------------------------------------
package krf_pkg;

  localparam int MAX_LEN_DEF    = 4096;
  localparam int MAX_WINDOW_DEF = 32;

  localparam int SYM_W    = 8;
  localparam int CODE_W   = 8;
  localparam int DIST_W   = 9;
  localparam int KEY_W    = 64;
  localparam int WIN_CFG_W = 6;
  localparam int CUT_W    = 13;
  localparam int CFG_W    = 13;
  localparam int CNT_OUT_W = 13;
  localparam int SCORE_W  = 17;
  localparam int FRAC_W   = 16;
  localparam int NUM_SYMS = 256;

  // widest lengths and windows over the whole parameter range
  localparam int LEN_W_MAX = 17;
  localparam int WIN_W_MAX = 7;

  localparam int Q_DEPTH = 2;

  localparam logic [WIN_CFG_W-1:0] WINDOW_RST = 6'd11;
  localparam logic [CUT_W-1:0]     CUTOFF_RST = 13'd2;

  typedef enum logic [0:0] {
    CFG_WINDOW = 1'b0,
    CFG_CUTOFF = 1'b1
  } cfg_idx_t;

  // one finished sequence handed from front to back
  typedef struct packed {
    logic [LEN_W_MAX-1:0] len;
    logic [DIST_W-1:0]    distinct;
    logic [WIN_W_MAX-1:0] window;
    logic [CUT_W-1:0]     cutoff;
    logic                 ovf;
  } desc_t;

  // symbol buffer write request
  typedef struct packed {
    logic                 we;
    logic [LEN_W_MAX-1:0] addr;
    logic [CODE_W-1:0]    data;
  } buf_wr_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_POW,
    BK_KRD,
    BK_KMUL,
    BK_KADD,
    BK_SPASS,
    BK_SBLK,
    BK_SRD,
    BK_SCMP,
    BK_CRD,
    BK_CCMP,
    BK_CFIN,
    BK_DSTART,
    BK_DWAIT,
    BK_OUT
  } bk_state_t;

endpackage

// ===== hdl/krf_front.sv =====
// ---------------------------------------------------------------------------
// krf_front
// Takes bytes, assigns codes in order of first appearance, writes the
// code buffer and hands a descriptor on at the end of each sequence.
// ---------------------------------------------------------------------------
module krf_front import krf_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_last,
  input  logic              buf_busy,
  input  logic              q_empty,
  output logic              q_push,
  output desc_t             q_data,
  output buf_wr_t           bw
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [WIN_CFG_W-1:0] window_r;
  logic [CUT_W-1:0]     cutoff_r;

  logic [NUM_SYMS-1:0] valid_r, valid_nxt;
  logic [DIST_W-1:0]   distinct_r, distinct_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic                ovf_r, ovf_nxt;

  logic [CODE_W-1:0] code_mem [NUM_SYMS];
  logic [CODE_W-1:0] code_rd_r;

  logic              s2_v_r, s2_last_r;
  logic              s2_we_r, s2_new_r;
  logic [AW-1:0]     s2_addr_r;
  logic [CODE_W-1:0] s2_ncode_r;
  desc_t             s2_desc_r;

  logic                 accept, room, is_new;
  logic [WIN_W_MAX-1:0] win_clamp;
  desc_t                desc_nxt;

  assign in_stall = s2_last_r || !q_empty || buf_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    room   = len_r < LW'(MAX_LEN);
    is_new = room && !valid_r[in_symbol];

    if (window_r == '0) begin
      win_clamp = WIN_W_MAX'(1);
    end else if (32'(window_r) > MAX_WINDOW) begin
      win_clamp = WIN_W_MAX'(MAX_WINDOW);
    end else begin
      win_clamp = WIN_W_MAX'(window_r);
    end

    valid_nxt    = valid_r;
    distinct_nxt = distinct_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    if (accept) begin
      if (room) begin
        len_nxt = len_r + LW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (is_new) begin
        valid_nxt[in_symbol] = 1'b1;
        distinct_nxt         = distinct_r + DIST_W'(1);
      end
    end

    desc_nxt.len      = LEN_W_MAX'(len_nxt);
    desc_nxt.distinct = distinct_nxt;
    desc_nxt.window   = win_clamp;
    desc_nxt.cutoff   = cutoff_r;
    desc_nxt.ovf      = ovf_nxt;

    // sequence ends: code map and counters start over
    if (accept && in_last) begin
      valid_nxt    = '0;
      distinct_nxt = '0;
      len_nxt      = '0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RST;
      cutoff_r   <= CUTOFF_RST;
      valid_r    <= '0;
      distinct_r <= '0;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      s2_v_r     <= 1'b0;
      s2_last_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: window_r <= cfg_data[WIN_CFG_W-1:0];
          CFG_CUTOFF: cutoff_r <= cfg_data[CUT_W-1:0];
          default:    ;
        endcase
      end
      valid_r    <= valid_nxt;
      distinct_r <= distinct_nxt;
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
      s2_v_r     <= accept;
      s2_last_r  <= accept && in_last;
    end
  end

  // second stage payload; the map read is registered and lands in the cycle after the request
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_new) begin
        code_mem[in_symbol] <= distinct_r[CODE_W-1:0];
      end
      code_rd_r  <= code_mem[in_symbol];
      s2_we_r    <= room;
      s2_new_r   <= is_new;
      s2_addr_r  <= len_r[AW-1:0];
      s2_ncode_r <= distinct_r[CODE_W-1:0];
      s2_desc_r  <= desc_nxt;
    end
  end

  assign bw.we   = s2_v_r && s2_we_r;
  assign bw.addr = LEN_W_MAX'(s2_addr_r);
  assign bw.data = s2_new_r ? s2_ncode_r : code_rd_r;
  assign q_push  = s2_last_r;
  assign q_data  = s2_desc_r;

endmodule

// ===== hdl/krf_queue.sv =====
// ---------------------------------------------------------------------------
// krf_queue
// Short descriptor queue between the front and the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module krf_queue import krf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CNTW = $clog2(Q_DEPTH + 1);

  desc_t           mem [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign empty = cnt_r == '0;
  assign full  = cnt_r == CNTW'(Q_DEPTH);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr_r <= (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `KRF_ASSERT_IMP(a_q_no_overrun, push, !full, "descriptor pushed into full queue")
  `KRF_ASSERT_IMP(a_q_no_underrun, pop, !empty, "descriptor popped from empty queue")

endmodule

// ===== hdl/krf_div.sv =====
// ---------------------------------------------------------------------------
// krf_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module krf_div #(
  parameter int DEND_W = 29,
  parameter int DSOR_W = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DEND_W-1:0] dividend,
  input  logic [DSOR_W-1:0] divisor,
  output logic              done,
  output logic [DEND_W-1:0] quotient
);

  localparam int CNTW = $clog2(DEND_W + 1);

  logic              busy_r, done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DEND_W-1:0] q_r;
  logic [DSOR_W:0]   rem_r;
  logic [DSOR_W:0]   rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem_r[DSOR_W-1:0], q_r[DEND_W-1]};
    fits   = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, divisor} : rem_sh;
      q_r   <= {q_r[DEND_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== hdl/krf_back.sv =====
// ---------------------------------------------------------------------------
// krf_back
// Per-sequence engine: window keys, merge sort, group count and score.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module krf_back import krf_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  buf_wr_t              bw,
  input  logic                 q_empty,
  input  desc_t                q_head,
  output logic                 q_pop,
  output logic                 buf_busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_OUT_W-1:0] out_repeat_windows,
  output logic [CNT_OUT_W-1:0] out_window_count,
  output logic [SCORE_W-1:0]   out_score_q16,
  output logic                 out_too_short,
  output logic                 out_overflow
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = LW + 3;
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int DW = LW + FRAC_W;

  bk_state_t state_r, state_nxt;

  // sequence data
  logic [LW-1:0]     len_r, len_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [DIST_W-1:0] base_r, base_nxt;
  logic [CUT_W-1:0]  cut_r, cut_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ts_r, ts_nxt;
  logic [LW-1:0]     nw_r, nw_nxt;

  // key forming
  logic [KEY_W-1:0]  pw_r, pw_nxt;
  logic [WW-1:0]     pcnt_r, pcnt_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic [KEY_W-1:0]  k_r, k_nxt, prod_r, prod_nxt, sub_r, sub_nxt;
  logic [CODE_W-1:0] c0_r, c0_nxt;

  // merge sort
  logic [CW-1:0] width_r, width_nxt, lo_r, lo_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt, o_r, o_nxt;
  logic          src_r, src_nxt;

  // grouping
  logic [KEY_W-1:0] prev_r, prev_nxt;
  logic [LW-1:0]    grp_r, grp_nxt, rep_r, rep_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_OUT_W-1:0] out_rep_r, out_nw_r;
  logic [SCORE_W-1:0]   out_score_r;
  logic                 out_ts_r, out_ovf_r;
  logic                 out_load;

  // memories
  logic [CODE_W-1:0] buf_mem [MAX_LEN];
  logic [KEY_W-1:0]  key_a [MAX_LEN];
  logic [KEY_W-1:0]  key_b [MAX_LEN];
  logic [CODE_W-1:0] brd0_r, brd1_r;
  logic [KEY_W-1:0]  ka0_r, ka1_r, kb0_r, kb1_r;
  logic [AW-1:0]     bra0, bra1, ra0, ra1, kwaddr;
  logic [KEY_W-1:0]  kwdata;
  logic              kwe_a, kwe_b;

  logic             div_start, div_done;
  logic [DW-1:0]    div_q;

  logic [CW-1:0]    sum_lw, sum_l2w, nw_c, iw;
  logic [KEY_W-1:0] da, db, knew;
  logic             take_b;

  always_ff @(posedge clk) begin
    if (bw.we) begin
      buf_mem[bw.addr[AW-1:0]] <= bw.data;
    end
    brd0_r <= buf_mem[bra0];
    brd1_r <= buf_mem[bra1];
  end

  always_ff @(posedge clk) begin
    if (kwe_a) begin
      key_a[kwaddr] <= kwdata;
    end
    ka0_r <= key_a[ra0];
    ka1_r <= key_a[ra1];
  end

  always_ff @(posedge clk) begin
    if (kwe_b) begin
      key_b[kwaddr] <= kwdata;
    end
    kb0_r <= key_b[ra0];
    kb1_r <= key_b[ra1];
  end

  krf_div #(
    .DEND_W (DW),
    .DSOR_W (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({rep_r, FRAC_W'(0)}),
    .divisor  (nw_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign buf_busy = (state_r == BK_POW) || (state_r == BK_KRD) ||
                    (state_r == BK_KMUL) || (state_r == BK_KADD);

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    w_nxt     = w_r;
    base_nxt  = base_r;
    cut_nxt   = cut_r;
    ovf_nxt   = ovf_r;
    ts_nxt    = ts_r;
    nw_nxt    = nw_r;
    pw_nxt    = pw_r;
    pcnt_nxt  = pcnt_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    prod_nxt  = prod_r;
    sub_nxt   = sub_r;
    c0_nxt    = c0_r;
    width_nxt = width_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    o_nxt     = o_r;
    src_nxt   = src_r;
    prev_nxt  = prev_r;
    grp_nxt   = grp_r;
    rep_nxt   = rep_r;
    score_nxt = score_r;

    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    bra0      = idx_r[AW-1:0];
    bra1      = '0;
    ra0       = '0;
    ra1       = '0;
    kwe_a     = 1'b0;
    kwe_b     = 1'b0;
    kwaddr    = idx_r[AW-1:0];
    kwdata    = '0;

    nw_c    = CW'(nw_r);
    iw      = CW'(idx_r) + CW'(w_r);
    sum_lw  = lo_r + width_r;
    sum_l2w = lo_r + (width_r << 1);
    da      = src_r ? kb0_r : ka0_r;
    db      = src_r ? kb1_r : ka1_r;
    take_b  = (a_r >= mid_r) || ((b_r < hi_r) && (db < da));
    knew    = prod_r + KEY_W'(c0_r) - sub_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          len_nxt  = LW'(q_head.len);
          w_nxt    = WW'(q_head.window);
          base_nxt = q_head.distinct;
          cut_nxt  = q_head.cutoff;
          ovf_nxt  = q_head.ovf;
          pw_nxt   = KEY_W'(1);
          pcnt_nxt = '0;
          if (CW'(LW'(q_head.len)) < CW'(q_head.window)) begin
            ts_nxt    = 1'b1;
            rep_nxt   = '0;
            nw_nxt    = '0;
            score_nxt = '0;
            state_nxt = BK_OUT;
          end else begin
            ts_nxt    = 1'b0;
            nw_nxt    = LW'(q_head.len) - LW'(q_head.window) + LW'(1);
            state_nxt = BK_POW;
          end
        end
      end
      // base^w, one multiply per cycle
      BK_POW: begin
        if (pcnt_r == w_r) begin
          idx_nxt   = len_r - LW'(1);
          k_nxt     = '0;
          state_nxt = BK_KRD;
        end else begin
          pw_nxt   = pw_r * KEY_W'(base_r);
          pcnt_nxt = pcnt_r + WW'(1);
        end
      end
      // rolling key from the tail: k = k*base + c[i] - c[i+w]*base^w
      BK_KRD: begin
        bra0      = idx_r[AW-1:0];
        bra1      = iw[AW-1:0];
        state_nxt = BK_KMUL;
      end
      BK_KMUL: begin
        prod_nxt  = k_r * KEY_W'(base_r);
        sub_nxt   = (iw < CW'(len_r)) ? KEY_W'(brd1_r) * pw_r : '0;
        c0_nxt    = brd0_r;
        state_nxt = BK_KADD;
      end
      BK_KADD: begin
        k_nxt  = knew;
        kwdata = knew;
        kwe_a  = idx_r < nw_r;
        if (idx_r == '0) begin
          width_nxt = CW'(1);
          src_nxt   = 1'b0;
          state_nxt = BK_SPASS;
        end else begin
          idx_nxt   = idx_r - LW'(1);
          state_nxt = BK_KRD;
        end
      end
      BK_SPASS: begin
        if (width_r >= nw_c) begin
          idx_nxt   = '0;
          grp_nxt   = '0;
          rep_nxt   = '0;
          state_nxt = BK_CRD;
        end else begin
          lo_nxt    = '0;
          state_nxt = BK_SBLK;
        end
      end
      BK_SBLK: begin
        if (lo_r >= nw_c) begin
          width_nxt = width_r << 1;
          src_nxt   = !src_r;
          state_nxt = BK_SPASS;
        end else begin
          mid_nxt   = (sum_lw < nw_c) ? sum_lw : nw_c;
          hi_nxt    = (sum_l2w < nw_c) ? sum_l2w : nw_c;
          a_nxt     = lo_r;
          b_nxt     = (sum_lw < nw_c) ? sum_lw : nw_c;
          o_nxt     = lo_r;
          state_nxt = BK_SRD;
        end
      end
      BK_SRD: begin
        ra0 = a_r[AW-1:0];
        ra1 = b_r[AW-1:0];
        if (o_r >= hi_r) begin
          lo_nxt    = sum_l2w;
          state_nxt = BK_SBLK;
        end else begin
          state_nxt = BK_SCMP;
        end
      end
      BK_SCMP: begin
        kwaddr = o_r[AW-1:0];
        kwdata = take_b ? db : da;
        kwe_a  = src_r;
        kwe_b  = !src_r;
        if (take_b) begin
          b_nxt = b_r + CW'(1);
        end else begin
          a_nxt = a_r + CW'(1);
        end
        o_nxt     = o_r + CW'(1);
        state_nxt = BK_SRD;
      end
      BK_CRD: begin
        ra0 = idx_r[AW-1:0];
        if (idx_r == nw_r) begin
          state_nxt = BK_CFIN;
        end else begin
          state_nxt = BK_CCMP;
        end
      end
      BK_CCMP: begin
        if (idx_r == '0 || da == prev_r) begin
          grp_nxt = grp_r + LW'(1);
        end else begin
          if (32'(grp_r) > 32'(cut_r)) begin
            rep_nxt = rep_r + grp_r;
          end
          grp_nxt = LW'(1);
        end
        prev_nxt  = da;
        idx_nxt   = idx_r + LW'(1);
        state_nxt = BK_CRD;
      end
      BK_CFIN: begin
        if (32'(grp_r) > 32'(cut_r)) begin
          rep_nxt = rep_r + grp_r;
        end
        state_nxt = BK_DSTART;
      end
      BK_DSTART: begin
        div_start = 1'b1;
        state_nxt = BK_DWAIT;
      end
      BK_DWAIT: begin
        if (div_done) begin
          score_nxt = div_q[SCORE_W-1:0];
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    w_r     <= w_nxt;
    base_r  <= base_nxt;
    cut_r   <= cut_nxt;
    ovf_r   <= ovf_nxt;
    ts_r    <= ts_nxt;
    nw_r    <= nw_nxt;
    pw_r    <= pw_nxt;
    pcnt_r  <= pcnt_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    prod_r  <= prod_nxt;
    sub_r   <= sub_nxt;
    c0_r    <= c0_nxt;
    width_r <= width_nxt;
    lo_r    <= lo_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    o_r     <= o_nxt;
    src_r   <= src_nxt;
    prev_r  <= prev_nxt;
    grp_r   <= grp_nxt;
    rep_r   <= rep_nxt;
    score_r <= score_nxt;
    if (out_load) begin
      out_rep_r   <= CNT_OUT_W'(rep_r);
      out_nw_r    <= CNT_OUT_W'(nw_r);
      out_score_r <= score_r;
      out_ts_r    <= ts_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_repeat_windows = out_rep_r;
  assign out_window_count   = out_nw_r;
  assign out_score_q16      = out_score_r;
  assign out_too_short      = out_ts_r;
  assign out_overflow       = out_ovf_r;

  `KRF_ASSERT_IMP(a_short_zero, out_valid_r && out_ts_r,
    out_rep_r == '0 && out_nw_r == '0 && out_score_r == '0,
    "short sequence result carries nonzero fields")
  `KRF_ASSERT_IMP(a_score_range, out_valid_r, out_score_r <= SCORE_W'(65536),
    "score above one")
  `KRF_ASSERT(a_pop_idle, !q_pop || (state_r == BK_IDLE && !out_load),
    "descriptor taken while engine busy")

endmodule

// ===== hdl/kmer_repeat_fraction.sv =====
// ---------------------------------------------------------------------------
// kmer_repeat_fraction
// Repeat score of a byte sequence by counting equal k-mer window keys.
// ---------------------------------------------------------------------------
// Usage: bytes of one sequence come in on in_symbol, one request per byte,
// in_last flagging the final byte. One result request follows per sequence
// on the out_ channel: repeat window count, window count, Q1.16 score and the
// too_short / overflow flags. Registers window_size (index 0) and dup_cutoff
// (index 1) are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, the block does not enforce it. Bytes load at
// one per cycle while in_stall is low. After the last byte the engine forms
// base^w by repeated multiplies, forms rolling keys from the tail (two buffer
// read ports, one multiply stage, one add stage), merge sorts the keys over
// ceil(log2(windows)) passes on the ping-pong key memories, counts groups of
// equal keys and divides in the bit-serial divider. The merge sort dominates.
// in_stall rises from the last byte until the keys of that sequence are
// formed; the next sequence may then load while the sort runs. If that one
// ends while the engine is still busy, in_stall holds until it is taken.
// Reset clears all control state and sets window_size to 11, dup_cutoff to 2.
// A stalled result is held in the output register and the engine waits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kmer_repeat_fraction import krf_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SYM_W-1:0]     in_symbol,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_OUT_W-1:0] out_repeat_windows,
  output logic [CNT_OUT_W-1:0] out_window_count,
  output logic [SCORE_W-1:0]   out_score_q16,
  output logic                 out_too_short,
  output logic                 out_overflow
);

  logic    buf_busy, q_empty, q_full, q_push, q_pop;
  desc_t   q_data, q_head;
  buf_wr_t bw;

  krf_front #(
    .MAX_LEN    (MAX_LEN),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .in_last   (in_last),
    .buf_busy  (buf_busy),
    .q_empty   (q_empty),
    .q_push    (q_push),
    .q_data    (q_data),
    .bw        (bw)
  );

  krf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  krf_back #(
    .MAX_LEN    (MAX_LEN),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .bw                 (bw),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .buf_busy           (buf_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_repeat_windows (out_repeat_windows),
    .out_window_count   (out_window_count),
    .out_score_q16      (out_score_q16),
    .out_too_short      (out_too_short),
    .out_overflow       (out_overflow)
  );

  // the buffer must not take new bytes while keys are read from it
  `KRF_ASSERT_IMP(a_buf_guard, buf_busy || q_full, in_stall,
    "byte accepted while symbol buffer in use")

endmodule
